/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, reports through $error.
`define HWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Signal must not be high.
`define HWT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/hwt_pkg.sv */
// Package for the highest walkable triangle search: widths, codes, micro-op table,
// and the command/status structs between controller and datapath. No dependencies.
package hwt_pkg;

	localparam int HWT_COORD_BITS  = 20;
	localparam int HWT_INDEX_BITS  = 16;
	localparam int HWT_FLOOR_RESET = -160000;

	localparam int UOP_BITS      = 5;
	localparam logic [UOP_BITS-1:0] UOP_WALK_LAST = 5'd8;
	localparam logic [UOP_BITS-1:0] UOP_LAST      = 5'd24;

	localparam logic [1:0] STATUS_FOUND  = 2'd0;
	localparam logic [1:0] STATUS_NO_BOX = 2'd1;
	localparam logic [1:0] STATUS_STEEP  = 2'd2;
	localparam logic [1:0] STATUS_NOT_IN = 2'd3;

	// operand sources
	localparam logic [3:0] SRC_UX  = 4'd0;
	localparam logic [3:0] SRC_UY  = 4'd1;
	localparam logic [3:0] SRC_UZ  = 4'd2;
	localparam logic [3:0] SRC_VX  = 4'd3;
	localparam logic [3:0] SRC_VY  = 4'd4;
	localparam logic [3:0] SRC_VZ  = 4'd5;
	localparam logic [3:0] SRC_WX  = 4'd6;
	localparam logic [3:0] SRC_WY  = 4'd7;
	localparam logic [3:0] SRC_NX  = 4'd8;
	localparam logic [3:0] SRC_NY  = 4'd9;
	localparam logic [3:0] SRC_NZ  = 4'd10;
	localparam logic [3:0] SRC_D00 = 4'd11;
	localparam logic [3:0] SRC_D01 = 4'd12;
	localparam logic [3:0] SRC_D02 = 4'd13;
	localparam logic [3:0] SRC_D11 = 4'd14;
	localparam logic [3:0] SRC_D12 = 4'd15;

	// accumulator modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_LOAD3 = 2'd1;
	localparam logic [1:0] MODE_ADD   = 2'd2;
	localparam logic [1:0] MODE_SUB   = 2'd3;

	// result destinations
	localparam logic [3:0] DST_NONE = 4'd0;
	localparam logic [3:0] DST_NX   = 4'd1;
	localparam logic [3:0] DST_NY   = 4'd2;
	localparam logic [3:0] DST_NZ   = 4'd3;
	localparam logic [3:0] DST_D00  = 4'd4;
	localparam logic [3:0] DST_D01  = 4'd5;
	localparam logic [3:0] DST_D02  = 4'd6;
	localparam logic [3:0] DST_D11  = 4'd7;
	localparam logic [3:0] DST_D12  = 4'd8;
	localparam logic [3:0] DST_DEN  = 4'd9;
	localparam logic [3:0] DST_UN   = 4'd10;
	localparam logic [3:0] DST_VN   = 4'd11;

	typedef struct packed {
		logic [3:0] src_a;
		logic [3:0] src_b;
		logic [1:0] mode;
		logic [3:0] dst;
	} uop_t;

	typedef struct packed {
		logic                load;
		logic                mul_start;
		logic                mul_step;
		logic                mul_msb;
		logic                acc_apply;
		logic                steep_set;
		logic                inside_eval;
		logic                div_start;
		logic                div_step;
		logic                out_load;
		logic [UOP_BITS-1:0] uop;
	} hwt_cmd_t;

	typedef struct packed {
		logic out_box;
		logic walk_ok;
		logic last;
	} hwt_sts_t;

	function automatic uop_t uop_decode(input logic [UOP_BITS-1:0] uop);
		uop_t r;
		unique case (uop)
			5'd0:  r = '{SRC_UY,  SRC_VZ,  MODE_LOAD,  DST_NONE};
			5'd1:  r = '{SRC_UZ,  SRC_VY,  MODE_SUB,   DST_NX};
			5'd2:  r = '{SRC_UZ,  SRC_VX,  MODE_LOAD,  DST_NONE};
			5'd3:  r = '{SRC_UX,  SRC_VZ,  MODE_SUB,   DST_NY};
			5'd4:  r = '{SRC_UX,  SRC_VY,  MODE_LOAD,  DST_NONE};
			5'd5:  r = '{SRC_UY,  SRC_VX,  MODE_SUB,   DST_NZ};
			5'd6:  r = '{SRC_NZ,  SRC_NZ,  MODE_LOAD3, DST_NONE};
			5'd7:  r = '{SRC_NX,  SRC_NX,  MODE_SUB,   DST_NONE};
			5'd8:  r = '{SRC_NY,  SRC_NY,  MODE_SUB,   DST_NONE};
			5'd9:  r = '{SRC_VX,  SRC_VX,  MODE_LOAD,  DST_NONE};
			5'd10: r = '{SRC_VY,  SRC_VY,  MODE_ADD,   DST_D00};
			5'd11: r = '{SRC_VX,  SRC_UX,  MODE_LOAD,  DST_NONE};
			5'd12: r = '{SRC_VY,  SRC_UY,  MODE_ADD,   DST_D01};
			5'd13: r = '{SRC_VX,  SRC_WX,  MODE_LOAD,  DST_NONE};
			5'd14: r = '{SRC_VY,  SRC_WY,  MODE_ADD,   DST_D02};
			5'd15: r = '{SRC_UX,  SRC_UX,  MODE_LOAD,  DST_NONE};
			5'd16: r = '{SRC_UY,  SRC_UY,  MODE_ADD,   DST_D11};
			5'd17: r = '{SRC_UX,  SRC_WX,  MODE_LOAD,  DST_NONE};
			5'd18: r = '{SRC_UY,  SRC_WY,  MODE_ADD,   DST_D12};
			5'd19: r = '{SRC_D00, SRC_D11, MODE_LOAD,  DST_NONE};
			5'd20: r = '{SRC_D01, SRC_D01, MODE_SUB,   DST_DEN};
			5'd21: r = '{SRC_D11, SRC_D02, MODE_LOAD,  DST_NONE};
			5'd22: r = '{SRC_D01, SRC_D12, MODE_SUB,   DST_UN};
			5'd23: r = '{SRC_D00, SRC_D12, MODE_LOAD,  DST_NONE};
			5'd24: r = '{SRC_D01, SRC_D02, MODE_SUB,   DST_VN};
			default: r = '{SRC_UX, SRC_UX, MODE_LOAD,  DST_NONE};
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/hwt_ctrl.sv */
// Controller state machine for the triangle search: sequences the micro-ops,
// multiply bit steps and the divide by three. Depends on hwt_pkg.
module hwt_ctrl import hwt_pkg::*; #(
	parameter int COORD_BITS = HWT_COORD_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  hwt_sts_t sts,
	output hwt_cmd_t cmd
);

	localparam int OPW = 2 * (COORD_BITS + 1) + 1;
	localparam int CW  = $clog2(OPW);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_BOX    = 4'd1;
	localparam logic [3:0] S_LDOP   = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_ACC    = 4'd4;
	localparam logic [3:0] S_WALK   = 4'd5;
	localparam logic [3:0] S_INSIDE = 4'd6;
	localparam logic [3:0] S_FINISH = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]          state_q, state_d;
	logic [UOP_BITS-1:0] uop_q, uop_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic                out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		uop_d   = uop_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.uop = uop_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_BOX;
				end
			end
			S_BOX: begin
				uop_d   = '0;
				state_d = sts.out_box ? S_FINISH : S_LDOP;
			end
			S_LDOP: begin
				cmd.mul_start = 1'b1;
				cnt_d         = '0;
				state_d       = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CW'(OPW - 1)) begin
					cmd.mul_msb = 1'b1;
					state_d     = S_ACC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_ACC: begin
				cmd.acc_apply = 1'b1;
				uop_d         = uop_q + 1'b1;
				if (uop_q == UOP_WALK_LAST)
					state_d = S_WALK;
				else if (uop_q == UOP_LAST)
					state_d = S_INSIDE;
				else
					state_d = S_LDOP;
			end
			S_WALK: begin
				if (!sts.walk_ok) begin
					cmd.steep_set = 1'b1;
					state_d       = S_FINISH;
				end else begin
					state_d = S_LDOP;
				end
			end
			S_INSIDE: begin
				cmd.inside_eval = 1'b1;
				state_d         = S_FINISH;
			end
			S_FINISH: begin
				if (sts.last) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			uop_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			uop_q   <= uop_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/hwt_datapath.sv */
// Datapath for the triangle search: edge vectors, shift-add multiplier, accumulator,
// run state, best candidate, divide by three and result register. Depends on hwt_pkg.
module hwt_datapath import hwt_pkg::*; #(
	parameter int COORD_BITS = HWT_COORD_BITS,
	parameter int INDEX_BITS = HWT_INDEX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hwt_cmd_t                     cmd,
	output hwt_sts_t                     sts,
	input  logic                         cfg_we,
	input  logic signed [COORD_BITS-1:0] cfg_data,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] vert_a_x,
	input  logic signed [COORD_BITS-1:0] vert_a_y,
	input  logic signed [COORD_BITS-1:0] vert_a_z,
	input  logic signed [COORD_BITS-1:0] vert_b_x,
	input  logic signed [COORD_BITS-1:0] vert_b_y,
	input  logic signed [COORD_BITS-1:0] vert_b_z,
	input  logic signed [COORD_BITS-1:0] vert_c_x,
	input  logic signed [COORD_BITS-1:0] vert_c_y,
	input  logic signed [COORD_BITS-1:0] vert_c_z,
	input  logic                         last_triangle,
	output logic [1:0]                   status,
	output logic signed [COORD_BITS-1:0] ground_height,
	output logic [INDEX_BITS-1:0]        triangle_number
);

	localparam int EW  = COORD_BITS + 1;
	localparam int OPW = 2 * EW + 1;
	localparam int PW  = 2 * OPW;
	localparam int AW  = PW + 2;
	localparam int XW  = AW + 2;
	localparam int ZW  = COORD_BITS + 2;
	localparam int QW  = ZW + 1;
	localparam int RK  = ZW;
	localparam logic [RK:0]   POW_K = {1'b1, {RK{1'b0}}};
	// reciprocal of 3, exact for dividends below 2^(RK-1)
	localparam logic [RK-1:0] RECIP = RK'(POW_K / 3 + 1);

	logic signed [EW-1:0]  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, wx_q, wy_q;
	logic signed [ZW-1:0]  zsum_q;
	logic                  last_q, out_box_q;
	logic [INDEX_BITS-1:0] number_q;
	logic signed [OPW-1:0] nx_q, ny_q, nz_q, d00_q, d01_q, d02_q, d11_q, d12_q;
	logic signed [AW-1:0]  den_q, un_q, vn_q, acc_q;
	logic signed [PW-1:0]  mcand_q, prod_q;
	logic [OPW-1:0]        mplier_q;
	logic signed [ZW-1:0]  best_q;
	logic [INDEX_BITS-1:0] best_num_q, count_q;
	logic                  found_q, box_seen_q, steep_q, outside_q;
	logic signed [COORD_BITS-1:0] floor_q;
	logic [QW-1:0]         div_num_q, quo_q;
	logic                  div_neg_q;
	logic [1:0]            status_q;
	logic signed [COORD_BITS-1:0] height_q;
	logic [INDEX_BITS-1:0] tri_q;

	uop_t                  dec;
	logic signed [OPW-1:0] opa, opb;
	logic signed [AW-1:0]  prod_ext, acc_d;
	logic signed [PW-1:0]  pp;
	logic                  box_out;
	logic signed [XW-1:0]  slack;
	logic                  inside_ok, cand;
	logic signed [ZW-1:0]  floor3;
	logic [QW-1:0]         mag, num;
	logic [QW+RK-1:0]      div_prod;
	logic signed [QW-1:0]  quo_s;

	function automatic logic signed [OPW-1:0] pick(input logic [3:0] s);
		logic signed [OPW-1:0] r;
		unique case (s)
			SRC_UX:  r = OPW'(ux_q);
			SRC_UY:  r = OPW'(uy_q);
			SRC_UZ:  r = OPW'(uz_q);
			SRC_VX:  r = OPW'(vx_q);
			SRC_VY:  r = OPW'(vy_q);
			SRC_VZ:  r = OPW'(vz_q);
			SRC_WX:  r = OPW'(wx_q);
			SRC_WY:  r = OPW'(wy_q);
			SRC_NX:  r = nx_q;
			SRC_NY:  r = ny_q;
			SRC_NZ:  r = nz_q;
			SRC_D00: r = d00_q;
			SRC_D01: r = d01_q;
			SRC_D02: r = d02_q;
			SRC_D11: r = d11_q;
			SRC_D12: r = d12_q;
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		dec      = uop_decode(cmd.uop);
		opa      = pick(dec.src_a);
		opb      = pick(dec.src_b);
		pp       = mplier_q[0] ? mcand_q : '0;
		prod_ext = AW'(prod_q);
		unique case (dec.mode)
			MODE_LOAD:  acc_d = prod_ext;
			MODE_LOAD3: acc_d = prod_ext + (prod_ext <<< 1);
			MODE_ADD:   acc_d = acc_q + prod_ext;
			MODE_SUB:   acc_d = acc_q - prod_ext;
			default:    acc_d = prod_ext;
		endcase
	end

	// point strictly off one side of the XY bounding box
	assign box_out =
		(point_x < vert_a_x && point_x < vert_b_x && point_x < vert_c_x) ||
		(vert_a_x < point_x && vert_b_x < point_x && vert_c_x < point_x) ||
		(point_y < vert_a_y && point_y < vert_b_y && point_y < vert_c_y) ||
		(vert_a_y < point_y && vert_b_y < point_y && vert_c_y < point_y);

	assign slack     = XW'(den_q) - XW'(un_q) - XW'(vn_q);
	assign inside_ok = (den_q > 0) && !un_q[AW-1] && !vn_q[AW-1] && !slack[XW-1];
	assign floor3    = ZW'(floor_q) + (ZW'(floor_q) <<< 1);
	assign cand      = (zsum_q > floor3) && (!found_q || zsum_q > best_q);

	assign mag      = QW'(-QW'(best_q));
	assign num      = best_q[ZW-1] ? mag + QW'(2) : QW'(best_q);
	assign div_prod = (QW+RK)'(div_num_q) * (QW+RK)'(RECIP);
	assign quo_s    = div_neg_q ? -$signed(quo_q) : $signed(quo_q);

	assign sts.out_box = out_box_q;
	assign sts.walk_ok = (nz_q > 0) && !acc_q[AW-1];
	assign sts.last    = last_q;

	assign status          = status_q;
	assign ground_height   = height_q;
	assign triangle_number = tri_q;

	// operand and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ux_q     <= EW'(vert_b_x) - EW'(vert_a_x);
			uy_q     <= EW'(vert_b_y) - EW'(vert_a_y);
			uz_q     <= EW'(vert_b_z) - EW'(vert_a_z);
			vx_q     <= EW'(vert_c_x) - EW'(vert_a_x);
			vy_q     <= EW'(vert_c_y) - EW'(vert_a_y);
			vz_q     <= EW'(vert_c_z) - EW'(vert_a_z);
			wx_q     <= EW'(point_x) - EW'(vert_a_x);
			wy_q     <= EW'(point_y) - EW'(vert_a_y);
			zsum_q   <= ZW'(vert_a_z) + ZW'(vert_b_z) + ZW'(vert_c_z);
			number_q <= count_q;
		end
		if (cmd.mul_start) begin
			mcand_q  <= PW'(opa);
			mplier_q <= opb;
			prod_q   <= '0;
		end else if (cmd.mul_step) begin
			prod_q   <= cmd.mul_msb ? prod_q - pp : prod_q + pp;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.acc_apply) begin
			acc_q <= acc_d;
			unique case (dec.dst)
				DST_NX:  nx_q  <= OPW'(acc_d);
				DST_NY:  ny_q  <= OPW'(acc_d);
				DST_NZ:  nz_q  <= OPW'(acc_d);
				DST_D00: d00_q <= OPW'(acc_d);
				DST_D01: d01_q <= OPW'(acc_d);
				DST_D02: d02_q <= OPW'(acc_d);
				DST_D11: d11_q <= OPW'(acc_d);
				DST_D12: d12_q <= OPW'(acc_d);
				DST_DEN: den_q <= acc_d;
				DST_UN:  un_q  <= acc_d;
				DST_VN:  vn_q  <= acc_d;
				default: ;
			endcase
		end
		if (cmd.inside_eval && inside_ok && cand) begin
			best_q     <= zsum_q;
			best_num_q <= number_q;
		end
		if (cmd.div_start) begin
			div_num_q <= num;
			div_neg_q <= best_q[ZW-1];
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			quo_q <= div_prod[RK +: QW];
		end
		if (cmd.out_load) begin
			if (found_q) begin
				status_q <= STATUS_FOUND;
				height_q <= COORD_BITS'(quo_s);
				tri_q    <= best_num_q;
			end else begin
				if (!box_seen_q)
					status_q <= STATUS_NO_BOX;
				else if (steep_q && !outside_q)
					status_q <= STATUS_STEEP;
				else
					status_q <= STATUS_NOT_IN;
				height_q <= floor_q;
				tri_q    <= '0;
			end
		end
	end

	// run state and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q    <= COORD_BITS'(HWT_FLOOR_RESET);
			count_q    <= '0;
			found_q    <= 1'b0;
			box_seen_q <= 1'b0;
			steep_q    <= 1'b0;
			outside_q  <= 1'b0;
			last_q     <= 1'b0;
			out_box_q  <= 1'b0;
		end else begin
			if (cfg_we)
				floor_q <= cfg_data;
			if (cmd.load) begin
				last_q    <= last_triangle;
				out_box_q <= box_out;
				if (!box_out)
					box_seen_q <= 1'b1;
				if (count_q != '1)
					count_q <= count_q + 1'b1;
			end
			if (cmd.steep_set)
				steep_q <= 1'b1;
			if (cmd.inside_eval) begin
				if (!inside_ok)
					outside_q <= 1'b1;
				else if (cand)
					found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				count_q    <= '0;
				found_q    <= 1'b0;
				box_seen_q <= 1'b0;
				steep_q    <= 1'b0;
				outside_q  <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/highest_walkable_triangle_search.sv */
// Top level of the highest walkable triangle search: controller plus datapath.
// Depends on hwt_pkg, hwt_ctrl and hwt_datapath.
//
// One triangle is taken at a time. A triangle whose XY box misses the point skips
// the multiplier. Otherwise one shared shift-add multiplier does the work, one
// operand bit per cycle: 9 products for the slope test and 25 for a walkable
// triangle. The last triangle of a run adds the divide by three and the result
// load. The result sits in an output register, so the next run can start while it
// waits. floor_height is written through the cfg port; the user is to write it only
// while idle, as the block itself does not enforce this.
module highest_walkable_triangle_search import hwt_pkg::*; #(
	parameter int COORD_BITS = HWT_COORD_BITS,
	parameter int INDEX_BITS = HWT_INDEX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic signed [COORD_BITS-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] vert_a_x,
	input  logic signed [COORD_BITS-1:0] vert_a_y,
	input  logic signed [COORD_BITS-1:0] vert_a_z,
	input  logic signed [COORD_BITS-1:0] vert_b_x,
	input  logic signed [COORD_BITS-1:0] vert_b_y,
	input  logic signed [COORD_BITS-1:0] vert_b_z,
	input  logic signed [COORD_BITS-1:0] vert_c_x,
	input  logic signed [COORD_BITS-1:0] vert_c_y,
	input  logic signed [COORD_BITS-1:0] vert_c_z,
	input  logic                         last_triangle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic signed [COORD_BITS-1:0] ground_height,
	output logic [INDEX_BITS-1:0]        triangle_number
);

	hwt_cmd_t cmd;
	hwt_sts_t sts;

	assign cfg_ready = 1'b1;

	hwt_ctrl #(
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hwt_datapath #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.point_x         (point_x),
		.point_y         (point_y),
		.vert_a_x        (vert_a_x),
		.vert_a_y        (vert_a_y),
		.vert_a_z        (vert_a_z),
		.vert_b_x        (vert_b_x),
		.vert_b_y        (vert_b_y),
		.vert_b_z        (vert_b_z),
		.vert_c_x        (vert_c_x),
		.vert_c_y        (vert_c_y),
		.vert_c_z        (vert_c_z),
		.last_triangle   (last_triangle),
		.status          (status),
		.ground_height   (ground_height),
		.triangle_number (triangle_number)
	);

endmodule

/* rtl/core/hwt_checker.sv */
// Port-level checker for highest_walkable_triangle_search, bound to the top level.
// Depends on hwt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hwt_checker import hwt_pkg::*; #(
	parameter int INDEX_BITS = HWT_INDEX_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            status,
	input logic [INDEX_BITS-1:0] triangle_number
);

	`HWT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
	`HWT_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second beat taken while busy")
	`HWT_NEVER(a_num_zero, out_valid && status != STATUS_FOUND && triangle_number != '0, "number without hit")
	`HWT_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without work")

endmodule

bind highest_walkable_triangle_search hwt_checker #(
	.INDEX_BITS(INDEX_BITS)
) u_hwt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.triangle_number (triangle_number)
);

/* tb/sv/hwt_scoreboard.sv */
// Checker for highest_walkable_triangle_search: watches the cfg, input and result
// channels, predicts each run's result and compares it field by field.
// Depends on hwt_pkg.
module hwt_scoreboard import hwt_pkg::*; (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic signed [HWT_COORD_BITS-1:0]   cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [HWT_COORD_BITS-1:0]   point_x,
	input  logic signed [HWT_COORD_BITS-1:0]   point_y,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_a_x,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_a_y,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_a_z,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_b_x,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_b_y,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_b_z,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_c_x,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_c_y,
	input  logic signed [HWT_COORD_BITS-1:0]   vert_c_z,
	input  logic                               last_triangle,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [1:0]                         status,
	input  logic signed [HWT_COORD_BITS-1:0]   ground_height,
	input  logic [HWT_INDEX_BITS-1:0]          triangle_number,
	output int                                 fail_count,
	output int                                 pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0]                status;
		logic [HWT_COORD_BITS-1:0] height;
		logic [HWT_INDEX_BITS-1:0] number;
	} ground_result_t;

	ground_result_t ground_q[$];

	logic signed [HWT_COORD_BITS-1:0] floor_h;
	logic signed [23:0]               best_sum;
	logic [HWT_INDEX_BITS-1:0]        best_idx;
	logic [HWT_INDEX_BITS-1:0]        tri_count;
	logic                             found, box_hit, steep, outside;

	assign pending = ground_q.size();

	function automatic logic slope_ok(wide_t ux, wide_t uy, wide_t uz,
			wide_t vx, wide_t vy, wide_t vz);
		wide_t nx, ny, nz;
		nx = uy * vz - uz * vy;
		ny = uz * vx - ux * vz;
		nz = ux * vy - uy * vx;
		return nz > 0 && 3 * nz * nz >= nx * nx + ny * ny;
	endfunction

	function automatic logic covers(wide_t v0x, wide_t v0y, wide_t v1x, wide_t v1y,
			wide_t v2x, wide_t v2y);
		wide_t d00, d01, d02, d11, d12, den, un, vn;
		d00 = v0x * v0x + v0y * v0y;
		d01 = v0x * v1x + v0y * v1y;
		d02 = v0x * v2x + v0y * v2y;
		d11 = v1x * v1x + v1y * v1y;
		d12 = v1x * v2x + v1y * v2y;
		den = d00 * d11 - d01 * d01;
		un  = d11 * d02 - d01 * d12;
		vn  = d00 * d12 - d01 * d02;
		return den > 0 && un >= 0 && vn >= 0 && un + vn <= den;
	endfunction

	task automatic clear_run();
		best_sum  = 24'(floor_h * 3);
		best_idx  = '0;
		found     = 1'b0;
		tri_count = '0;
		box_hit   = 1'b0;
		steep     = 1'b0;
		outside   = 1'b0;
	endtask

	task automatic predict_triangle();
		wide_t px, py, ax, ay, az, ux, uy, uz, vx, vy, vz;
		logic signed [23:0] s, f3, q;
		logic [HWT_INDEX_BITS-1:0] idx;
		logic miss;
		ground_result_t r;
		idx = tri_count;
		if (tri_count != '1)
			tri_count = tri_count + 1'b1;
		miss = (point_x < vert_a_x && point_x < vert_b_x && point_x < vert_c_x) ||
			(point_x > vert_a_x && point_x > vert_b_x && point_x > vert_c_x) ||
			(point_y < vert_a_y && point_y < vert_b_y && point_y < vert_c_y) ||
			(point_y > vert_a_y && point_y > vert_b_y && point_y > vert_c_y);
		if (!miss) begin
			px = point_x; py = point_y;
			ax = vert_a_x; ay = vert_a_y; az = vert_a_z;
			ux = wide_t'(vert_b_x) - ax; uy = wide_t'(vert_b_y) - ay;
			uz = wide_t'(vert_b_z) - az;
			vx = wide_t'(vert_c_x) - ax; vy = wide_t'(vert_c_y) - ay;
			vz = wide_t'(vert_c_z) - az;
			box_hit = 1'b1;
			if (!slope_ok(ux, uy, uz, vx, vy, vz)) begin
				steep = 1'b1;
			end else if (covers(vx, vy, ux, uy, px - ax, py - ay)) begin
				s  = 24'(vert_a_z) + 24'(vert_b_z) + 24'(vert_c_z);
				f3 = 24'(floor_h * 3);
				if (f3 < s && (!found || best_sum < s)) begin
					best_sum = s;
					best_idx = idx;
					found    = 1'b1;
				end
			end else begin
				outside = 1'b1;
			end
		end
		if (last_triangle) begin
			if (found) begin
				q = 24'(best_sum / 3);
				if (best_sum < 0 && best_sum % 3 != 0)
					q = q - 24'sd1;
				r.status = STATUS_FOUND;
				r.height = q[HWT_COORD_BITS-1:0];
				r.number = best_idx;
			end else begin
				r.status = !box_hit ? STATUS_NO_BOX :
					(steep && !outside) ? STATUS_STEEP : STATUS_NOT_IN;
				r.height = floor_h;
				r.number = '0;
			end
			ground_q = {ground_q, r};
			clear_run();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ground_result_t e;
		if (!arst_n) begin
			floor_h    = HWT_COORD_BITS'(HWT_FLOOR_RESET);
			fail_count = 0;
			ground_q.delete();
			clear_run();
		end else begin
			if (cfg_valid && cfg_ready)
				floor_h = cfg_data;
			if (in_valid && in_ready)
				predict_triangle();
			if (out_valid && out_ready) begin
				if (ground_q.size() == 0) begin
					$error("result beat with no result expected");
					fail_count++;
				end else begin
					e = ground_q.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						fail_count++;
					end
					if (ground_height !== e.height) begin
						$error("ground_height: expected %0d, got %0d",
							$signed(e.height), ground_height);
						fail_count++;
					end
					if (triangle_number !== e.number) begin
						$error("triangle_number: expected %0d, got %0d",
							e.number, triangle_number);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* tb/sv/tb_highest_walkable_triangle_search.sv */
// Testbench top for highest_walkable_triangle_search: clock, reset, stimulus,
// floor_height writes and verdict. Depends on hwt_pkg, hwt_scoreboard and highest_walkable_triangle_search.
module tb_highest_walkable_triangle_search;
	import hwt_pkg::*;

	localparam int CB       = HWT_COORD_BITS;
	localparam int N_ITEMS  = 550;
	localparam int WD_LIMIT = 20000;

	typedef struct {
		logic [CB-1:0] px, py, ax, ay, az, bx, by, bz, cx, cy, cz;
		logic          last;
	} triangle_t;

	logic                  clk, arst_n;
	logic                  cfg_valid, cfg_ready;
	logic signed [CB-1:0]  cfg_data;
	logic                  in_valid, in_ready;
	logic signed [CB-1:0]  point_x, point_y;
	logic signed [CB-1:0]  vert_a_x, vert_a_y, vert_a_z;
	logic signed [CB-1:0]  vert_b_x, vert_b_y, vert_b_z;
	logic signed [CB-1:0]  vert_c_x, vert_c_y, vert_c_z;
	logic                  last_triangle;
	logic                  out_valid, out_ready;
	logic [1:0]            status;
	logic signed [CB-1:0]  ground_height;
	logic [HWT_INDEX_BITS-1:0] triangle_number;
	int                    fail_count, pending;
	int                    idle_cycles, burst_left, sent;

	highest_walkable_triangle_search DUT (.*);
	hwt_scoreboard checker_i (.*);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// result side stall pattern, picks a new character each time its counter wraps
	always @(negedge clk) begin
		int mode, cnt;
		if (cnt == 0)
			mode = $urandom_range(0, 2);
		cnt = (cnt + 1) % 64;
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic triangle_t mk(int px, int py, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz, logic last);
		triangle_t t;
		t.px = CB'(px); t.py = CB'(py);
		t.ax = CB'(ax); t.ay = CB'(ay); t.az = CB'(az);
		t.bx = CB'(bx); t.by = CB'(by); t.bz = CB'(bz);
		t.cx = CB'(cx); t.cy = CB'(cy); t.cz = CB'(cz);
		t.last = last;
		return t;
	endfunction

	function automatic int jit(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic triangle_t rand_tri(int px, int py, logic last);
		int span, zb, zs, kind;
		span = ($urandom_range(0, 3) == 0) ? 20000 : ($urandom_range(0, 1) ? 500 : 16);
		zb   = $urandom_range(0, 400000) - 200000;
		kind = $urandom_range(0, 9);
		zs   = (kind < 7) ? span / 4 : span * 8;
		if (kind == 0)
			return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, last);
		if (kind < 4)
			return mk(px, py, px + span + jit(span), py + jit(span), zb + jit(zs),
				px + span + jit(span), py + jit(span), zb + jit(zs),
				px + span + jit(span), py + jit(span), zb + jit(zs), last);
		return mk(px, py, px - span + jit(span / 2), py - span + jit(span / 2),
			zb + jit(zs), px + span + jit(span / 2), py - span + jit(span / 2),
			zb + jit(zs), px + jit(span), py + span + jit(span / 2), zb + jit(zs), last);
	endfunction

	task automatic send(triangle_t t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		point_x <= t.px; point_y <= t.py;
		vert_a_x <= t.ax; vert_a_y <= t.ay; vert_a_z <= t.az;
		vert_b_x <= t.bx; vert_b_y <= t.by; vert_b_z <= t.bz;
		vert_c_x <= t.cx; vert_c_y <= t.cy; vert_c_z <= t.cz;
		last_triangle <= t.last;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_floor(int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= CB'(value);
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int px, py, len;
		in_valid = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
		point_x = '0; point_y = '0; last_triangle = 1'b0;
		vert_a_x = '0; vert_a_y = '0; vert_a_z = '0;
		vert_b_x = '0; vert_b_y = '0; vert_b_z = '0;
		vert_c_x = '0; vert_c_y = '0; vert_c_z = '0;
		out_ready = 1'b0; idle_cycles = 0; burst_left = 0; sent = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: box miss, degenerate, tie, wrong winding, outside, below floor
		send(mk(0, 0, 10, 0, 0, 20, 5, 0, 30, 9, 0, 1'b1));
		send(mk(100, 100, 100, 100, 5, 100, 100, 5, 100, 100, 5, 1'b1));
		send(mk(0, 0, -10, -10, 30, 10, -10, 30, 0, 10, 30, 1'b0));
		send(mk(0, 0, -10, -10, 30, 10, -10, 30, 0, 10, 30, 1'b0));
		send(mk(0, 0, -10, -10, 90, 10, -10, 90, 0, 10, 90, 1'b1));
		send(mk(0, 0, -10, -10, 0, 0, 10, 0, 10, -10, 0, 1'b1));
		send(mk(9, 9, -10, -10, 0, 10, -10, 0, -10, 10, 0, 1'b1));
		send(mk(0, 0, -10, -10, -200000, 10, -10, -200000, 0, 10, -200000, 1'b1));
		send(mk(0, 0, -10, -10, 0, 0, 10, 0, 10, -10, 0, 1'b0));
		send(mk(0, 0, -524288, -524288, -524288, 524287, -524288, -524288,
			0, 524287, -524287, 1'b1));
		send(mk(-524288, 524287, -524288, 524287, 524287, -524288, 524287, 524287,
			-524288, 524287, 524287, 1'b1));
		write_floor(-524288);
		send(mk(0, 0, -10, -10, -524288, 10, -10, -524288, 0, 10, -524287, 1'b1));
		write_floor(524287);
		send(mk(0, 0, -10, -10, 524287, 10, -10, 524287, 0, 10, 524287, 1'b1));
		write_floor(0);
		send(mk(0, 0, -10, -10, 0, 10, -10, 0, 0, 10, 1, 1'b1));

		while (sent < N_ITEMS) begin
			if (sent % 110 < 6 && sent > 20) begin
				case ($urandom_range(0, 3))
					0: write_floor(-524288);
					1: write_floor(524287);
					2: write_floor(-160000);
					default: write_floor($urandom_range(0, 400000) - 200000);
				endcase
			end
			px = $urandom_range(0, 800000) - 400000;
			py = $urandom_range(0, 800000) - 400000;
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send(rand_tri(px, py, i == len - 1));
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
